FILE: sv/bcdec_pkg.sv
// ============================================================================
// bcdec_pkg : shared types and helpers for the BC1/BC2/BC3 block decoder
// Format codes, stage payload structs, endpoint widening and the
// divide-by-constant helpers used by the interpolation stage.
// ============================================================================
package bcdec_pkg;

  // block_format codes; code 3 decodes as BC1
  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  // configuration register map
  localparam int         CFG_ADDR_W       = 3;
  localparam logic [0:0] REG_BLOCK_FORMAT = 1'b0;

  localparam int NUM_PIX = 16;
  localparam int NUM_CH  = 3;   // blue, green, red

  typedef logic [7:0] chan_t;

  // stage handshake: valid of the upstream stage, and the advance enable
  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

  // endpoint stage result: widened endpoints and interpolation numerators
  typedef struct packed {
    logic [1:0]               mode;
    logic                     three_col;
    logic                     six_step;
    logic [NUM_CH-1:0][7:0]   p0;
    logic [NUM_CH-1:0][7:0]   p1;
    logic [NUM_CH-1:0][9:0]   sum2;
    logic [NUM_CH-1:0][9:0]   sum3;
    logic [NUM_CH-1:0][7:0]   avg;
    logic [7:0]               a0;
    logic [7:0]               a1;
    logic [6:1][10:0]         anum;
    logic [31:0]              idx;
    logic [63:0]              abits;
  } prep_t;

  // finished block: colour palette, alpha table and per-pixel codes
  typedef struct packed {
    logic [1:0]                    mode;
    logic [3:0][NUM_CH-1:0][7:0]   pal;
    logic                          col3_clear;
    logic [7:0][7:0]               atab;
    logic [31:0]                   idx;
    logic [63:0]                   abits;
  } blk_t;

  function automatic chan_t widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic chan_t widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic chan_t widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  // x / 3 for x < 2048: (x * 683) >> 11
  function automatic chan_t div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // x / 7 for x < 5461: (x * 2341) >> 14
  function automatic chan_t div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // x / 5 for x < 2730: (x * 1639) >> 13
  function automatic chan_t div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

endpackage

FILE: sv/bcdec_prep.sv
// ============================================================================
// bcdec_prep : endpoint stage
// Pick the colour half, widen the 565 endpoints and form the numerators of
// the colour and alpha interpolations.
// ============================================================================
module bcdec_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcdec_pkg::pipe_ctl_t ctl,
  input  logic [1:0]           mode,
  input  logic [63:0]          w0,
  input  logic [63:0]          w1,
  output logic                 valid_o,
  output bcdec_pkg::prep_t     prep_o
);

  logic              valid_r;
  bcdec_pkg::prep_t  prep_r;
  bcdec_pkg::prep_t  prep_nxt;
  logic              four;
  logic [63:0]       cw;
  logic [15:0]       e0;
  logic [15:0]       e1;
  logic [8:0]        s9;

  always_comb begin
    four = (mode == bcdec_pkg::FMT_BC2) || (mode == bcdec_pkg::FMT_BC3);
    cw   = four ? w1 : w0;
    e0   = cw[15:0];
    e1   = cw[31:16];

    prep_nxt           = '0;
    prep_nxt.mode      = mode;
    prep_nxt.three_col = !four && (e0 <= e1);
    prep_nxt.p0[0]     = bcdec_pkg::widen5(e0[4:0]);
    prep_nxt.p0[1]     = bcdec_pkg::widen6(e0[10:5]);
    prep_nxt.p0[2]     = bcdec_pkg::widen5(e0[15:11]);
    prep_nxt.p1[0]     = bcdec_pkg::widen5(e1[4:0]);
    prep_nxt.p1[1]     = bcdec_pkg::widen6(e1[10:5]);
    prep_nxt.p1[2]     = bcdec_pkg::widen5(e1[15:11]);
    s9                 = '0;
    for (int c = 0; c < bcdec_pkg::NUM_CH; c++) begin
      prep_nxt.sum2[c] = {1'b0, prep_nxt.p0[c], 1'b0} + {2'b00, prep_nxt.p1[c]};
      prep_nxt.sum3[c] = {2'b00, prep_nxt.p0[c]} + {1'b0, prep_nxt.p1[c], 1'b0};
      s9               = {1'b0, prep_nxt.p0[c]} + {1'b0, prep_nxt.p1[c]};
      prep_nxt.avg[c]  = s9[8:1];
    end

    prep_nxt.a0       = w0[7:0];
    prep_nxt.a1       = w0[15:8];
    prep_nxt.six_step = (w0[7:0] <= w0[15:8]);
    for (int k = 1; k < 7; k++) begin
      if (!prep_nxt.six_step) begin
        prep_nxt.anum[k] = 11'(7 - k) * {3'b000, prep_nxt.a0}
                         + 11'(k) * {3'b000, prep_nxt.a1};
      end else if (k < 5) begin
        prep_nxt.anum[k] = 11'(5 - k) * {3'b000, prep_nxt.a0}
                         + 11'(k) * {3'b000, prep_nxt.a1};
      end else begin
        prep_nxt.anum[k] = '0;
      end
    end

    prep_nxt.idx   = cw[63:32];
    prep_nxt.abits = w0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.advance) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prep_r <= prep_nxt;
    end
  end

  assign valid_o = valid_r;
  assign prep_o  = prep_r;

endmodule

FILE: sv/bcdec_div.sv
// ============================================================================
// bcdec_div : interpolation stage
// Divide the numerators by 3, 5 or 7 through reciprocal multiplies and
// build the four-entry palette and eight-entry alpha table.
// ============================================================================
module bcdec_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcdec_pkg::pipe_ctl_t ctl,
  input  bcdec_pkg::prep_t     prep_i,
  output logic                 valid_o,
  output bcdec_pkg::blk_t      blk_o
);

  logic             valid_r;
  bcdec_pkg::blk_t  blk_r;
  bcdec_pkg::blk_t  blk_nxt;

  always_comb begin
    blk_nxt            = '0;
    blk_nxt.mode       = prep_i.mode;
    blk_nxt.col3_clear = prep_i.three_col;
    for (int c = 0; c < bcdec_pkg::NUM_CH; c++) begin
      blk_nxt.pal[0][c] = prep_i.p0[c];
      blk_nxt.pal[1][c] = prep_i.p1[c];
      if (prep_i.three_col) begin
        blk_nxt.pal[2][c] = prep_i.avg[c];
        blk_nxt.pal[3][c] = '0;
      end else begin
        blk_nxt.pal[2][c] = bcdec_pkg::div3(prep_i.sum2[c]);
        blk_nxt.pal[3][c] = bcdec_pkg::div3(prep_i.sum3[c]);
      end
    end

    blk_nxt.atab[0] = prep_i.a0;
    blk_nxt.atab[1] = prep_i.a1;
    for (int k = 1; k < 7; k++) begin
      if (!prep_i.six_step) begin
        blk_nxt.atab[k+1] = bcdec_pkg::div7(prep_i.anum[k]);
      end else if (k < 5) begin
        blk_nxt.atab[k+1] = bcdec_pkg::div5(prep_i.anum[k]);
      end else if (k == 5) begin
        blk_nxt.atab[k+1] = 8'h00;
      end else begin
        blk_nxt.atab[k+1] = 8'hff;
      end
    end

    blk_nxt.idx   = prep_i.idx;
    blk_nxt.abits = prep_i.abits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.advance) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      blk_r <= blk_nxt;
    end
  end

  assign valid_o = valid_r;
  assign blk_o   = blk_r;

endmodule

FILE: sv/bcdec_serial.sv
// ============================================================================
// bcdec_serial : pixel sequencer
// Hold one decoded block and emit its sixteen pixels, one per cycle, from
// a registered output stage.
// ============================================================================
module bcdec_serial (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             blk_valid,
  input  bcdec_pkg::blk_t  blk_i,
  output logic             ready_o,
  output logic             out_valid,
  output logic [3:0]       out_pixel_index,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_green,
  output logic [7:0]       out_red,
  output logic [7:0]       out_alpha,
  output logic             out_last_pixel
);

  localparam logic [3:0] LAST_PIX = 4'(bcdec_pkg::NUM_PIX - 1);

  bcdec_pkg::blk_t  hb_r;
  logic             hv_r;
  logic             hv_nxt;
  logic [3:0]       cnt_r;
  logic [3:0]       cnt_nxt;
  logic             load;
  logic [1:0]       ci;
  logic [5:0]       sh;
  logic [2:0]       acode;
  logic [7:0]       alpha_nxt;

  logic             ov_r;
  logic [3:0]       pix_r;
  logic [7:0]       blue_r;
  logic [7:0]       green_r;
  logic [7:0]       red_r;
  logic [7:0]       alpha_r;
  logic             last_r;

  assign ready_o = !hv_r || (cnt_r == LAST_PIX);
  assign load    = blk_valid && ready_o;

  always_comb begin
    hv_nxt  = hv_r;
    cnt_nxt = cnt_r;
    if (load) begin
      hv_nxt  = 1'b1;
      cnt_nxt = '0;
    end else if (hv_r) begin
      if (cnt_r == LAST_PIX) begin
        hv_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + 4'd1;
    end
  end

  always_comb begin
    ci    = hb_r.idx[{cnt_r, 1'b0} +: 2];
    sh    = 6'd16 + {2'b00, cnt_r} + {1'b0, cnt_r, 1'b0};
    acode = hb_r.abits[sh +: 3];
    case (hb_r.mode)
      bcdec_pkg::FMT_BC2: begin
        alpha_nxt = bcdec_pkg::widen4(hb_r.abits[{cnt_r, 2'b00} +: 4]);
      end
      bcdec_pkg::FMT_BC3: begin
        alpha_nxt = hb_r.atab[acode];
      end
      default: begin
        alpha_nxt = (hb_r.col3_clear && (ci == 2'd3)) ? 8'h00 : 8'hff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r  <= 1'b0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      hv_r  <= hv_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= hv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hb_r <= blk_i;
    end
    pix_r   <= cnt_r;
    blue_r  <= hb_r.pal[ci][0];
    green_r <= hb_r.pal[ci][1];
    red_r   <= hb_r.pal[ci][2];
    alpha_r <= alpha_nxt;
    last_r  <= (cnt_r == LAST_PIX);
  end

  assign out_valid       = ov_r;
  assign out_pixel_index = pix_r;
  assign out_blue        = blue_r;
  assign out_green       = green_r;
  assign out_red         = red_r;
  assign out_alpha       = alpha_r;
  assign out_last_pixel  = last_r;

endmodule

FILE: sv/bc1_bc2_bc3_block_decoder.sv
// ============================================================================
// bc1_bc2_bc3_block_decoder : BC1/BC2/BC3 4x4 block decoder, top level
// Path: an accepted block passes the capture registers, bcdec_prep,
//   bcdec_div and the pixel sequencer before the registered pixel outputs.
// Throughput: the pixel sequencer emits one pixel beat per cycle while it
//   holds a block; the receiver cannot stall.
// Reset: synchronous, active low; clears all valid bits, the sequencer and
//   block_format (BC1).
// ============================================================================
module bc1_bc2_bc3_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_first_word,
  input  logic [63:0] in_second_word,
  // result channel
  output logic        out_valid,
  output logic [3:0]  out_pixel_index,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha,
  output logic        out_last_pixel,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bcdec_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // --------------------------------------------------------------------------
  // Configuration register. One register, block_format, at byte address 0.
  // Writes to any other index are dropped; reads there return zero.
  // --------------------------------------------------------------------------
  logic [1:0] fmt_r;
  logic [1:0] fmt_nxt;
  logic       cfg_wr;
  logic       cfg_sel_fmt;

  assign pready      = 1'b1;
  assign cfg_sel_fmt = (paddr[bcdec_pkg::CFG_ADDR_W-1:2] == bcdec_pkg::REG_BLOCK_FORMAT);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign fmt_nxt     = (cfg_wr && cfg_sel_fmt) ? pwdata[1:0] : fmt_r;
  assign prdata      = cfg_sel_fmt ? {30'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= bcdec_pkg::FMT_BC1;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline:
  //   stage 1  capture the block and the format it decodes under
  //   stage 2  endpoint widening and interpolation numerators (bcdec_prep)
  //   stage 3  reciprocal divides, palette and alpha table (bcdec_div)
  //   stage 4  pixel sequencer with its registered output (bcdec_serial)
  // Each stage advances when it is empty or the next one advances, so a
  // held block never drops or repeats. The sequencer takes a new block on
  // the cycle its last pixel goes out, keeping the output gapless.
  // --------------------------------------------------------------------------
  logic        v1_r;
  logic        v1_nxt;
  logic [63:0] w0_r;
  logic [63:0] w1_r;
  logic [1:0]  mode_r;
  logic        accept;

  logic        v2;
  logic        v3;
  logic        seq_ready;
  logic        s1_adv;
  logic        s2_adv;
  logic        s3_adv;

  bcdec_pkg::prep_t     prep;
  bcdec_pkg::blk_t      blk;
  bcdec_pkg::pipe_ctl_t ctl2;
  bcdec_pkg::pipe_ctl_t ctl3;

  // backpressure chain, sequencer back to the capture stage
  assign s3_adv = !v3 || seq_ready;
  assign s2_adv = !v2 || s3_adv;
  assign s1_adv = !v1_r || s2_adv;

  // hold off new blocks while the capture stage cannot move on
  assign busy   = !s1_adv;
  assign accept = start && !busy;
  assign v1_nxt = s1_adv ? accept : v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w0_r   <= in_first_word;
      w1_r   <= in_second_word;
      mode_r <= fmt_r;
    end
  end

  assign ctl2.valid   = v1_r;
  assign ctl2.advance = s2_adv;
  assign ctl3.valid   = v2;
  assign ctl3.advance = s3_adv;

  bcdec_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl2),
    .mode    (mode_r),
    .w0      (w0_r),
    .w1      (w1_r),
    .valid_o (v2),
    .prep_o  (prep)
  );

  bcdec_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl3),
    .prep_i  (prep),
    .valid_o (v3),
    .blk_o   (blk)
  );

  bcdec_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .blk_valid       (v3),
    .blk_i           (blk),
    .ready_o         (seq_ready),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_blue        (out_blue),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_alpha       (out_alpha),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
